// ----- src/tlbrm_pkg.sv -----
// Shared constants, codes and control types of the TLB region mapper.
package tlbrm_pkg;

    localparam int SLOT_COUNT  = 64;
    localparam int SIZE_CODES  = 8;
    localparam int MAX_RESULTS = 64;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int K_W    = $clog2(MAX_RESULTS);

    localparam logic [2:0] ST_WRITTEN   = 3'd0;
    localparam logic [2:0] ST_FREED     = 3'd1;
    localparam logic [2:0] ST_START_MIS = 3'd2;
    localparam logic [2:0] ST_LEN_MIS   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    localparam logic [2:0] KIND_EXEC       = 3'd0;
    localparam logic [2:0] KIND_RO_NOCACHE = 3'd2;
    localparam logic [2:0] KIND_RW         = 3'd3;
    localparam logic [2:0] KIND_RW_NOCACHE = 3'd4;
    localparam logic [2:0] KIND_RW_EXEC    = 3'd5;

    localparam logic [31:0] OPT_EX    = 32'h0000_0200;
    localparam logic [31:0] OPT_WR    = 32'h0000_0100;
    localparam logic [31:0] OPT_I     = 32'h0000_0005;
    localparam logic [31:0] TAG_VALID = 32'h0000_0040;
    localparam logic [31:0] MASK_1K   = 32'h0000_03FF;

    typedef enum logic [4:0] {
        SOP_IDLE = 5'b00001,
        SOP_AIM  = 5'b00010,
        SOP_LOAD = 5'b00100,
        SOP_STEP = 5'b01000,
        SOP_FREE = 5'b10000
    } slot_op_t;

    typedef struct packed {
        slot_op_t            op;
        logic [SLOT_W-1:0]   load_idx;
        logic                in_range;
    } slot_ctrl_t;

    typedef struct packed {
        logic                at_last;
        logic                is_free;
        logic [SLOT_W-1:0]   idx;
        logic [CNT_W-1:0]    used_next;
    } slot_stat_t;

endpackage

// ----- src/tlbrm_slot_table.sv -----
// Free-slot bitmap with a rotating one-slot-per-cycle search pointer.
module tlbrm_slot_table
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlbrm_pkg::slot_ctrl_t  ctrl,
    output tlbrm_pkg::slot_stat_t  stat
);

    logic [tlbrm_pkg::SLOT_COUNT-1:0] free_reg, free_next;
    logic [tlbrm_pkg::SLOT_W-1:0]     idx_reg, idx_next;
    logic [tlbrm_pkg::SLOT_W-1:0]     last_reg, last_next;
    logic [tlbrm_pkg::CNT_W-1:0]      used_reg, used_next;
    logic [tlbrm_pkg::SLOT_W-1:0]     idx_inc;
    logic [tlbrm_pkg::SLOT_W-1:0]     last_inc;
    logic [tlbrm_pkg::SLOT_W-1:0]     idx_dec;
    logic                             at_last;
    logic                             is_free;

    localparam logic [tlbrm_pkg::SLOT_W-1:0] SLOT_TOP = tlbrm_pkg::SLOT_W'(tlbrm_pkg::SLOT_COUNT - 1);

    assign at_last  = (idx_reg == last_reg);
    assign is_free  = free_reg[idx_reg];
    assign idx_inc  = (idx_reg == SLOT_TOP) ? '0 : idx_reg + 1'b1;
    assign last_inc = (last_reg == SLOT_TOP) ? '0 : last_reg + 1'b1;
    assign idx_dec  = (idx_reg == '0) ? SLOT_TOP : idx_reg - 1'b1;

    always_comb
    begin
        free_next = free_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        used_next = used_reg;
        unique case (ctrl.op)
            tlbrm_pkg::SOP_IDLE:
            begin
            end
            tlbrm_pkg::SOP_AIM:
            begin
                idx_next = last_inc;
            end
            tlbrm_pkg::SOP_LOAD:
            begin
                idx_next = ctrl.load_idx;
            end
            tlbrm_pkg::SOP_STEP:
            begin
                if (!at_last)
                begin
                    if (is_free)
                    begin
                        free_next[idx_reg] = 1'b0;
                        last_next          = idx_reg;
                        used_next          = used_reg + 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            tlbrm_pkg::SOP_FREE:
            begin
                if (ctrl.in_range)
                begin
                    if (!is_free)
                    begin
                        free_next[idx_reg] = 1'b1;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - 1'b1;
                        end
                    end
                    last_next = idx_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            idx_reg  <= '0;
            last_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            free_reg <= free_next;
            idx_reg  <= idx_next;
            last_reg <= last_next;
            used_reg <= used_next;
        end
    end

    assign stat.at_last   = at_last;
    assign stat.is_free   = is_free;
    assign stat.idx       = idx_reg;
    assign stat.used_next = used_next;

endmodule

// ----- src/tlb_region_mapper.sv -----
// Top level of the TLB region mapper: request sequencer, block sizing and result register.
//
// Input stream (s_*): one item is a map request (s_tuser = 0) or a free command
// (s_tuser = 1). A map request is cut into aligned power-of-four blocks from 1K
// to 16M; each block claims a slot from a rotating search over 64 slots and
// yields one entry-write item on the output stream (m_*). m_tlast marks the
// final item of a request; m_tuser carries its status.
// Timing: s_tready is high only while the block is idle, so one request is
// worked at a time. A rejected request has its item set up in the check state,
// a free command in the free state that follows it. Each entry of a map request
// passes through block sizing (one size step per cycle through a shift-and-compare
// unit), then slot search (one slot probed per cycle), then the output state;
// a request emits at most 64 items.
// Reset: all slots free, search pointer at slot 0, count zero.
// Stall: a result waits in the output register while m_tready is low; the
// sequencer holds until it is taken.
module tlb_region_mapper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // start_addr, end_addr, access_kind, process_id, slot_index
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // entry_slot, tag_word, data_word, entry_pid, slots_in_use
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_FREE   = 7'b0000100,
        S_SIZE   = 7'b0001000,
        S_SEARCH = 7'b0010000,
        S_OUT    = 7'b0100000,
        S_SPARE  = 7'b1000000
    } state_t;

    localparam logic [2:0] CODE_MAX = 3'(tlbrm_pkg::SIZE_CODES - 1);
    localparam logic [tlbrm_pkg::K_W-1:0] K_LAST = tlbrm_pkg::K_W'(tlbrm_pkg::MAX_RESULTS - 1);

    state_t                       state_reg, state_next;
    logic                         cmd_reg, cmd_next;
    logic [31:0]                  addr_reg, addr_next;
    logic [31:0]                  nbytes_reg, nbytes_next;
    logic [31:0]                  opts_reg, opts_next;
    logic [7:0]                   pid_reg, pid_next;
    logic [5:0]                   sidx_reg, sidx_next;
    logic [31:0]                  mask_reg, mask_next;
    logic [2:0]                   code_reg, code_next;
    logic [tlbrm_pkg::K_W-1:0]    k_reg, k_next;
    logic                         out_valid_reg, out_valid_next;
    logic [5:0]                   out_slot_reg, out_slot_next;
    logic [31:0]                  out_tag_reg, out_tag_next;
    logic [31:0]                  out_data_reg, out_data_next;
    logic [7:0]                   out_pid_reg, out_pid_next;
    logic [2:0]                   out_status_reg, out_status_next;
    logic [6:0]                   out_used_reg, out_used_next;
    logic                         out_last_reg, out_last_next;

    tlbrm_pkg::slot_ctrl_t        slot_ctrl;
    tlbrm_pkg::slot_stat_t        slot_stat;

    logic [31:0]                  in_start;
    logic [31:0]                  in_end;
    logic [2:0]                   in_kind;
    logic [31:0]                  in_opts;
    logic [31:0]                  mask_cand;
    logic                         size_up;
    logic [31:0]                  blk_size;
    logic [31:0]                  nbytes_after;
    logic [6:0]                   used_ext;

    assign in_start = s_tdata[31:0];
    assign in_end   = s_tdata[63:32];
    assign in_kind  = s_tdata[66:64];

    always_comb
    begin
        in_opts = '0;
        if (in_kind == tlbrm_pkg::KIND_EXEC || in_kind == tlbrm_pkg::KIND_RW_EXEC)
        begin
            in_opts = in_opts | tlbrm_pkg::OPT_EX;
        end
        if (in_kind == tlbrm_pkg::KIND_RW || in_kind == tlbrm_pkg::KIND_RW_NOCACHE
            || in_kind == tlbrm_pkg::KIND_RW_EXEC)
        begin
            in_opts = in_opts | tlbrm_pkg::OPT_WR;
        end
        if (in_kind == tlbrm_pkg::KIND_RO_NOCACHE || in_kind == tlbrm_pkg::KIND_RW_NOCACHE)
        begin
            in_opts = in_opts | tlbrm_pkg::OPT_I;
        end
    end

    assign mask_cand    = {mask_reg[29:0], 2'b11};
    assign size_up      = (mask_cand < nbytes_reg) && ((addr_reg & mask_cand) == '0)
                          && (code_reg < CODE_MAX);
    assign blk_size     = mask_reg + 32'd1;
    assign nbytes_after = nbytes_reg - blk_size;
    assign used_ext     = 7'(slot_stat.used_next);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_used_reg, out_pid_reg, out_data_reg, out_tag_reg,
                       out_slot_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        slot_ctrl.op       = tlbrm_pkg::SOP_IDLE;
        slot_ctrl.load_idx = tlbrm_pkg::SLOT_W'(sidx_reg);
        slot_ctrl.in_range = ({1'b0, sidx_reg} < 7'(tlbrm_pkg::SLOT_COUNT));
        unique case (state_reg)
            S_CHECK:
            begin
                if (cmd_reg)
                begin
                    slot_ctrl.op = tlbrm_pkg::SOP_LOAD;
                end
            end
            S_FREE:
            begin
                slot_ctrl.op = tlbrm_pkg::SOP_FREE;
            end
            S_SIZE:
            begin
                if (!size_up)
                begin
                    slot_ctrl.op = tlbrm_pkg::SOP_AIM;
                end
            end
            S_SEARCH:
            begin
                slot_ctrl.op = tlbrm_pkg::SOP_STEP;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        addr_next          = addr_reg;
        nbytes_next        = nbytes_reg;
        opts_next          = opts_reg;
        pid_next           = pid_reg;
        sidx_next          = sidx_reg;
        mask_next          = mask_reg;
        code_next          = code_reg;
        k_next             = k_reg;
        out_valid_next     = out_valid_reg;
        out_slot_next      = out_slot_reg;
        out_tag_next       = out_tag_reg;
        out_data_next      = out_data_reg;
        out_pid_next       = out_pid_reg;
        out_status_next    = out_status_reg;
        out_used_next      = out_used_reg;
        out_last_next      = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tuser;
                    addr_next   = in_start;
                    nbytes_next = in_end - in_start + 32'd1;
                    opts_next   = in_opts;
                    pid_next    = s_tdata[74:67];
                    sidx_next   = s_tdata[80:75];
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                out_slot_next   = '0;
                out_tag_next    = '0;
                out_data_next   = '0;
                out_pid_next    = '0;
                out_used_next   = used_ext;
                out_last_next   = 1'b1;
                if (cmd_reg)
                begin
                    state_next   = S_FREE;
                end
                else if ((addr_reg & tlbrm_pkg::MASK_1K) != '0)
                begin
                    out_status_next = tlbrm_pkg::ST_START_MIS;
                    out_valid_next  = 1'b1;
                    state_next      = S_OUT;
                end
                else if ((nbytes_reg & tlbrm_pkg::MASK_1K) != '0)
                begin
                    out_status_next = tlbrm_pkg::ST_LEN_MIS;
                    out_valid_next  = 1'b1;
                    state_next      = S_OUT;
                end
                else if (nbytes_reg == '0)
                begin
                    out_status_next = tlbrm_pkg::ST_EMPTY;
                    out_valid_next  = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    mask_next  = tlbrm_pkg::MASK_1K;
                    code_next  = '0;
                    k_next     = '0;
                    state_next = S_SIZE;
                end
            end
            S_FREE:
            begin
                out_slot_next   = sidx_reg;
                out_tag_next    = '0;
                out_data_next   = '0;
                out_pid_next    = '0;
                out_status_next = tlbrm_pkg::ST_FREED;
                out_used_next   = used_ext;
                out_last_next   = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_OUT;
            end
            S_SIZE:
            begin
                if (size_up)
                begin
                    mask_next = mask_cand;
                    code_next = code_reg + 3'd1;
                end
                else
                begin
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (slot_stat.at_last)
                begin
                    out_slot_next   = '0;
                    out_tag_next    = '0;
                    out_data_next   = '0;
                    out_pid_next    = '0;
                    out_status_next = tlbrm_pkg::ST_FULL;
                    out_used_next   = used_ext;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_OUT;
                end
                else if (slot_stat.is_free)
                begin
                    out_slot_next  = 6'(slot_stat.idx);
                    out_tag_next   = addr_reg | {22'd0, code_reg, 7'd0} | tlbrm_pkg::TAG_VALID;
                    out_data_next  = addr_reg | opts_reg;
                    out_pid_next   = pid_reg;
                    out_used_next  = used_ext;
                    out_valid_next = 1'b1;
                    addr_next      = addr_reg + blk_size;
                    nbytes_next    = nbytes_after;
                    k_next         = k_reg + 1'b1;
                    state_next     = S_OUT;
                    if (nbytes_after == '0)
                    begin
                        out_status_next = tlbrm_pkg::ST_WRITTEN;
                        out_last_next   = 1'b1;
                    end
                    else if (k_reg == K_LAST)
                    begin
                        out_status_next = tlbrm_pkg::ST_FULL;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        out_status_next = tlbrm_pkg::ST_WRITTEN;
                        out_last_next   = 1'b0;
                    end
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mask_next  = tlbrm_pkg::MASK_1K;
                        code_next  = '0;
                        state_next = S_SIZE;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                state_next     = S_IDLE;
            end
        endcase
    end

    tlbrm_slot_table u_slot_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (slot_ctrl),
        .stat  (slot_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            cmd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        nbytes_reg     <= nbytes_next;
        opts_reg       <= opts_next;
        pid_reg        <= pid_next;
        sidx_reg       <= sidx_next;
        mask_reg       <= mask_next;
        code_reg       <= code_next;
        out_slot_reg   <= out_slot_next;
        out_tag_reg    <= out_tag_next;
        out_data_reg   <= out_data_next;
        out_pid_reg    <= out_pid_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ----- sim/tb.sv -----
// Testbench for tlb_region_mapper: directed table, then random map/free traffic with a predictor.
`timescale 1ns / 100ps

module tb;
    import tlbrm_pkg::*;

    localparam logic       CMD_MAP     = 1'b0;
    localparam logic       CMD_FREE    = 1'b1;
    localparam logic [2:0] KIND_RO     = 3'd1;
    localparam logic [2:0] KIND_ODD6   = 3'd6;
    localparam logic [2:0] KIND_ODD7   = 3'd7;
    localparam int         LIMIT       = 8_000_000;
    localparam int         RANDOM_REQS = 207;
    localparam int         MAX_REPORTS = 10;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       tag;
        logic [31:0]       data;
        logic [7:0]        pid;
        logic [2:0]        status;
        logic [CNT_W-1:0]  used;
        logic              last;
    } tlb_write_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] first_addr;
        logic [31:0] last_addr;
        logic [2:0]  kind;
        logic [7:0]  pid;
        logic [5:0]  sidx;
        logic        typed;
        tlb_write_t  want;
    } request_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic calm    = 1'b0;
    logic hold_go = 1'b0;
    logic hold_rx = 1'b0;

    logic [SLOT_COUNT-1:0] free_map;
    int                    rover;
    int                    in_use;

    tlb_write_t pending_writes[$];
    tlb_write_t region_out[$];

    int    accepted   = 0;
    int    map_count  = 0;
    int    free_count = 0;
    int    checked    = 0;
    int    full_seen  = 0;
    int    mismatches = 0;
    longint cycles    = 0;

    tlb_region_mapper i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tlb_write_t make_write(int slot, logic [31:0] tag, logic [31:0] data,
                                              logic [7:0] pid, logic [2:0] st, logic last);
        tlb_write_t w;
        w.slot   = SLOT_W'(slot);
        w.tag    = tag;
        w.data   = data;
        w.pid    = pid;
        w.status = st;
        w.used   = CNT_W'(in_use);
        w.last   = last;
        return w;
    endfunction

    function automatic tlb_write_t fixed_result(logic [2:0] st, int slot, int used);
        tlb_write_t w;
        w        = '0;
        w.slot   = SLOT_W'(slot);
        w.status = st;
        w.used   = CNT_W'(used);
        w.last   = 1'b1;
        return w;
    endfunction

    function automatic request_t row(logic cmd, logic [31:0] fa, logic [31:0] la,
                                     logic [2:0] kind, logic [7:0] pid, logic [5:0] sidx);
        request_t rq;
        rq.cmd        = cmd;
        rq.first_addr = fa;
        rq.last_addr  = la;
        rq.kind       = kind;
        rq.pid        = pid;
        rq.sidx       = sidx;
        rq.typed      = 1'b0;
        rq.want       = '0;
        return rq;
    endfunction

    function automatic request_t pinned(request_t rq, tlb_write_t w);
        rq.typed = 1'b1;
        rq.want  = w;
        return rq;
    endfunction

    // rotating search; never probes the slot the pointer rests on
    function automatic int claim_slot();
        int idx;
        idx = rover;
        while (1)
        begin
            idx = (idx + 1 >= SLOT_COUNT) ? 0 : idx + 1;
            if (idx == rover)
                return -1;
            if (free_map[idx])
            begin
                free_map[idx] = 1'b0;
                rover = idx;
                if (in_use < SLOT_COUNT)
                    in_use++;
                return idx;
            end
        end
        return -1;
    endfunction

    task automatic decompose_region(input request_t rq);
        logic [31:0] addr;
        logic [31:0] nbytes;
        logic [31:0] mask;
        logic [31:0] options;
        logic [31:0] size;
        logic [31:0] tag;
        int          code;
        int          k;
        int          slot;
        region_out.delete();
        if (rq.cmd == CMD_FREE)
        begin
            if (rq.sidx < SLOT_COUNT)
            begin
                if (!free_map[rq.sidx])
                begin
                    free_map[rq.sidx] = 1'b1;
                    if (in_use > 0)
                        in_use--;
                end
                rover = (rq.sidx == 0) ? SLOT_COUNT - 1 : rq.sidx - 1;
            end
            region_out.push_back(make_write(rq.sidx, '0, '0, '0, ST_FREED, 1'b1));
            return;
        end
        addr   = rq.first_addr;
        nbytes = rq.last_addr - rq.first_addr + 32'd1;
        if ((addr & MASK_1K) != 0)
        begin
            region_out.push_back(make_write(0, '0, '0, '0, ST_START_MIS, 1'b1));
            return;
        end
        if ((nbytes & MASK_1K) != 0)
        begin
            region_out.push_back(make_write(0, '0, '0, '0, ST_LEN_MIS, 1'b1));
            return;
        end
        if (nbytes == 0)
        begin
            region_out.push_back(make_write(0, '0, '0, '0, ST_EMPTY, 1'b1));
            return;
        end
        options = '0;
        if (rq.kind == KIND_EXEC || rq.kind == KIND_RW_EXEC)
            options |= OPT_EX;
        if (rq.kind == KIND_RW || rq.kind == KIND_RW_NOCACHE || rq.kind == KIND_RW_EXEC)
            options |= OPT_WR;
        if (rq.kind == KIND_RO_NOCACHE || rq.kind == KIND_RW_NOCACHE)
            options |= OPT_I;
        k = 0;
        while (nbytes != 0)
        begin
            mask = MASK_1K;
            code = 0;
            while (mask < nbytes && (addr & mask) == 0 && code < SIZE_CODES)
            begin
                mask = (mask << 2) + 32'd3;
                code++;
            end
            mask = mask >> 2;
            code = (code == 0) ? 0 : code - 1;
            slot = claim_slot();
            if (slot < 0)
            begin
                region_out.push_back(make_write(0, '0, '0, '0, ST_FULL, 1'b1));
                return;
            end
            tag    = addr | (32'(code) << 7) | TAG_VALID;
            size   = mask + 32'd1;
            region_out.push_back(make_write(slot, tag, addr | options, rq.pid, ST_WRITTEN,
                                            1'b0));
            addr   = addr + size;
            nbytes = nbytes - size;
            if (nbytes == 0)
            begin
                region_out[region_out.size()-1].last = 1'b1;
                return;
            end
            if (k == MAX_RESULTS - 1)
            begin
                region_out[region_out.size()-1].status = ST_FULL;
                region_out[region_out.size()-1].last   = 1'b1;
                return;
            end
            k++;
        end
    endtask

    function automatic request_t random_request();
        request_t rq;
        int       r;
        int       p_free;
        int       len_kb;
        int       pick;
        int       n;
        rq = row(CMD_MAP, $urandom, $urandom, 3'($urandom_range(0, 7)), 8'($urandom),
                 6'($urandom));
        p_free = (in_use > 40) ? 70 : 25;
        r = $urandom_range(0, 99);
        if (r < p_free)
        begin
            rq.cmd = CMD_FREE;
            if (in_use > 0 && $urandom_range(0, 9) != 0)
            begin
                pick = rq.sidx;
                for (n = 0; n < SLOT_COUNT && free_map[pick]; n++)
                    pick = (pick + 1) % SLOT_COUNT;
                rq.sidx = 6'(pick);
            end
        end
        else if (r < p_free + 12)
        begin
            case ($urandom_range(0, 3))
                0: rq.first_addr[9:0] = 10'($urandom_range(1, 1023));
                1:
                begin
                    rq.first_addr[9:0] = '0;
                    if (rq.last_addr[9:0] == 10'h3FF)
                        rq.last_addr[0] = 1'b0;
                end
                2:
                begin
                    rq.first_addr[9:0] = '0;
                    rq.last_addr = rq.first_addr - 32'd1;
                end
                default: ;
            endcase
        end
        else
        begin
            rq.first_addr[9:0] = '0;
            r = $urandom_range(0, 99);
            if (r < 70)
                len_kb = $urandom_range(1, 16);
            else if (r < 95)
                len_kb = $urandom_range(1, 4096);
            else
                len_kb = $urandom_range(1, (1 << 22) - 1);
            rq.last_addr = rq.first_addr + 32'(len_kb) * 32'd1024 - 32'd1;
        end
        return rq;
    endfunction

    task automatic offer(input request_t rq);
        s_tdata  <= {7'b0, rq.sidx, rq.pid, rq.kind, rq.last_addr, rq.first_addr};
        s_tuser  <= rq.cmd;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        accepted++;
        if (rq.cmd == CMD_FREE)
            free_count++;
        else
            map_count++;
        decompose_region(rq);
        if (rq.typed)
            pending_writes.push_back(rq.want);
        else
            foreach (region_out[i])
                pending_writes.push_back(region_out[i]);
        if (!calm && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : rx_check
        tlb_write_t got;
        tlb_write_t want;
        if (m_tvalid && m_tready)
        begin
            got.slot   = m_tdata[5:0];
            got.tag    = m_tdata[37:6];
            got.data   = m_tdata[69:38];
            got.pid    = m_tdata[77:70];
            got.used   = m_tdata[84:78];
            got.status = m_tuser;
            got.last   = m_tlast;
            if (pending_writes.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected item: slot %0d tag %h status %0d", got.slot, got.tag,
                             got.status);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                checked++;
                if (got.status == ST_FULL)
                    full_seen++;
                if (got !== want)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("mismatch exp: slot %0d tag %h data %h pid %h",
                                 want.slot, want.tag, want.data, want.pid);
                        $display("              st %0d used %0d last %0d",
                                 want.status, want.used, want.last);
                        $display("         got: slot %0d tag %h data %h pid %h",
                                 got.slot, got.tag, got.data, got.pid);
                        $display("              st %0d used %0d last %0d",
                                 got.status, got.used, got.last);
                    end
                    mismatches++;
                end
            end
        end
        if (hold_rx)
            m_tready <= 1'b0;
        else if (calm)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 29);
    end

    initial
    begin : holdoff
        do
            @(posedge clk);
        while (!hold_go);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        request_t script[$];
        int       n;
        free_map = '1;
        rover    = 0;
        in_use   = 0;

        script.push_back(pinned(row(CMD_MAP, 32'h0000_0001, 32'h0000_03FF, KIND_EXEC, 8'h00, 6'd0),
                                fixed_result(ST_START_MIS, 0, 0)));
        script.push_back(pinned(row(CMD_MAP, 32'hFFFF_FFFF, 32'h0, KIND_ODD7, 8'hFF, 6'h3F),
                                fixed_result(ST_START_MIS, 0, 0)));
        script.push_back(pinned(row(CMD_MAP, 32'h0, 32'h0000_0400, KIND_RO, 8'h01, 6'd0),
                                fixed_result(ST_LEN_MIS, 0, 0)));
        script.push_back(pinned(row(CMD_MAP, 32'h0000_0400, 32'h0000_07FE, KIND_RW, 8'h02, 6'd0),
                                fixed_result(ST_LEN_MIS, 0, 0)));
        script.push_back(pinned(row(CMD_MAP, 32'h0000_0400, 32'h0000_03FF, KIND_RW_EXEC, 8'h03,
                                    6'd0), fixed_result(ST_EMPTY, 0, 0)));
        script.push_back(pinned(row(CMD_MAP, 32'h0, 32'hFFFF_FFFF, KIND_RO_NOCACHE, 8'h04, 6'd0),
                                fixed_result(ST_EMPTY, 0, 0)));
        script.push_back(pinned(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd63),
                                fixed_result(ST_FREED, 63, 0)));
        script.push_back(pinned(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd0),
                                fixed_result(ST_FREED, 0, 0)));
        // more blocks than one request may write: stops at the result cap
        script.push_back(row(CMD_MAP, 32'h0000_0400, 32'hFFFF_FFFF, KIND_RW_EXEC, 8'hA5, 6'd0));
        script.push_back(pinned(row(CMD_MAP, 32'h0, 32'h0000_03FF, KIND_RO, 8'h3C, 6'd0),
                                fixed_result(ST_FULL, 0, SLOT_COUNT)));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd10));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd10));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd63));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd0));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd20));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd30));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd40));
        script.push_back(row(CMD_FREE, 32'h0, 32'h0, KIND_EXEC, 8'h00, 6'd50));
        script.push_back(row(CMD_MAP, 32'h0, 32'h0000_03FF, KIND_EXEC, 8'h11, 6'd0));
        script.push_back(row(CMD_MAP, 32'hFFFF_FC00, 32'hFFFF_FFFF, KIND_RO_NOCACHE, 8'h22, 6'd0));
        script.push_back(row(CMD_MAP, 32'h0100_0000, 32'h01FF_FFFF, KIND_RW, 8'h33, 6'd0));
        script.push_back(row(CMD_MAP, 32'h0200_0000, 32'h03FF_FFFF, KIND_RW_NOCACHE, 8'h44, 6'd0));
        // table runs out partway through the request
        script.push_back(row(CMD_MAP, 32'h0000_1000, 32'h0000_3FFF, KIND_ODD6, 8'h55, 6'd0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer(script[i]);

        for (n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == 60)
                calm <= 1'b1;
            if (n == 110)
                calm <= 1'b0;
            if (n == 150)
                hold_go <= 1'b1;
            offer(random_request());
        end
        s_tvalid <= 1'b0;

        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d requests (%0d map, %0d free) with random stalls and a long hold-off",
                 accepted, map_count, free_count);
        $display("checked %0d result items, %0d of them table-full", checked, full_seen);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tlbrm_pkg.sv
src/tlbrm_slot_table.sv
src/tlb_region_mapper.sv
sim/tb.sv
